// ===== rtl/dcpid_pkg.sv =====
package dcpid_pkg;

    localparam int NUM_CH      = 2;
    localparam int SPEED_W     = 16;
    localparam int ERR_W       = 17;
    localparam int SUM_W       = 16;
    localparam int RAW_SUM_W   = 18;
    localparam int GAIN_W      = 16;
    localparam int PROD_W      = 34;
    localparam int ACC_W       = 36;
    localparam int FRAC_W      = 8;
    localparam int OUT_W       = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    localparam int SETPOINT_W  = 8;
    localparam int BIAS_W      = 13;
    localparam int LIMIT_W     = 15;

    localparam logic [SETPOINT_W-1:0] SETPOINT_RST   = 8'd0;
    localparam logic [GAIN_W-1:0]     PROP_GAIN_RST  = 16'd38400;
    localparam logic [GAIN_W-1:0]     INTEG_GAIN_RST = 16'd4800;
    localparam logic [GAIN_W-1:0]     DERIV_GAIN_RST = 16'd845;
    localparam logic [BIAS_W-1:0]     BIAS_RST       = 13'd10;
    localparam logic [LIMIT_W-1:0]    LIMIT_RST      = 15'd450;
    localparam logic [OUT_W-1:0]      OUT_MAX_RST    = 16'd7200;
    localparam logic [ERR_W-1:0]      LAST_ERR_RST   = 17'sd5;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SETPOINT   = 3'd0,
        REG_PROP_GAIN  = 3'd1,
        REG_INTEG_GAIN = 3'd2,
        REG_DERIV_GAIN = 3'd3,
        REG_BIAS       = 3'd4,
        REG_LIMIT      = 3'd5,
        REG_OUT_MAX    = 3'd6
    } reg_idx_t;

    typedef logic signed [ERR_W-1:0]  err_t;
    typedef logic signed [SUM_W-1:0]  sum_t;
    typedef logic signed [PROD_W-1:0] prod_t;

endpackage

// ===== rtl/dual_channel_pid_speed_control.sv =====
// Two-channel positional PID speed controller. Each request carries a signed
// speed per motor; the block forms error = setpoint - |speed|, keeps a clamped
// integral and the previous error per channel, and returns one PWM compare
// value per channel, clamped to 0..output_max. The datapath is a four-stage
// pipeline (input, error/integral, products, output). One request is accepted
// every cycle unless m_ready stalls the output, since the integral and
// previous-error registers update as each request leaves the input stage. Gains
// are unsigned Q8.8. Configuration must be written only while no request is in
// flight; the block does not enforce this. No clearing pass runs after reset.
module dual_channel_pid_speed_control
    import dcpid_pkg::*;
(
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [SPEED_W-1:0]     s_left_speed,
    input  logic signed [SPEED_W-1:0]     s_right_speed,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic        [OUT_W-1:0]       m_left_compare,
    output logic        [OUT_W-1:0]       m_right_compare,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic        [CFG_IDX_W-1:0]   cfg_index,
    input  logic        [CFG_DATA_W-1:0]  cfg_data
);

    logic [SETPOINT_W-1:0] setpoint_reg;
    logic [GAIN_W-1:0]     prop_gain_reg;
    logic [GAIN_W-1:0]     integ_gain_reg;
    logic [GAIN_W-1:0]     deriv_gain_reg;
    logic [BIAS_W-1:0]     bias_reg;
    logic [LIMIT_W-1:0]    limit_reg;
    logic [OUT_W-1:0]      out_max_reg;

    logic v1_reg, v2_reg, v3_reg, m_valid_reg;
    logic free1, free2, free3, free_out;

    logic signed [SPEED_W-1:0] speed_reg [NUM_CH];
    err_t  err_reg      [NUM_CH];
    sum_t  int_reg      [NUM_CH];
    err_t  diff_reg     [NUM_CH];
    prod_t p_prod_reg   [NUM_CH];
    prod_t i_prod_reg   [NUM_CH];
    prod_t d_prod_reg   [NUM_CH];
    logic [OUT_W-1:0] cmp_reg [NUM_CH];

    sum_t  sum_state_reg [NUM_CH];
    err_t  last_err_reg  [NUM_CH];

    err_t  err_next  [NUM_CH];
    sum_t  int_next  [NUM_CH];
    err_t  diff_next [NUM_CH];
    logic [OUT_W-1:0] cmp_next [NUM_CH];

    // Configuration port.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            setpoint_reg   <= SETPOINT_RST;
            prop_gain_reg  <= PROP_GAIN_RST;
            integ_gain_reg <= INTEG_GAIN_RST;
            deriv_gain_reg <= DERIV_GAIN_RST;
            bias_reg       <= BIAS_RST;
            limit_reg      <= LIMIT_RST;
            out_max_reg    <= OUT_MAX_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_SETPOINT:   setpoint_reg   <= cfg_data[SETPOINT_W-1:0];
                REG_PROP_GAIN:  prop_gain_reg  <= cfg_data[GAIN_W-1:0];
                REG_INTEG_GAIN: integ_gain_reg <= cfg_data[GAIN_W-1:0];
                REG_DERIV_GAIN: deriv_gain_reg <= cfg_data[GAIN_W-1:0];
                REG_BIAS:       bias_reg       <= cfg_data[BIAS_W-1:0];
                REG_LIMIT:      limit_reg      <= cfg_data[LIMIT_W-1:0];
                REG_OUT_MAX:    out_max_reg    <= cfg_data[OUT_W-1:0];
                default: ;
            endcase
        end
    end

    // Each stage loads when it is empty or its content moves on.
    assign free_out = !m_valid_reg || m_ready;
    assign free3    = !v3_reg || free_out;
    assign free2    = !v2_reg || free3;
    assign free1    = !v1_reg || free2;
    assign s_ready  = free1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (free1)    v1_reg      <= s_valid;
            if (free2)    v2_reg      <= v1_reg;
            if (free3)    v3_reg      <= v2_reg;
            if (free_out) m_valid_reg <= v3_reg;
        end
    end

    // Stage 2 logic: error, clamped integral and error change.
    always_comb begin
        logic signed [ERR_W-1:0]     mag;
        logic signed [RAW_SUM_W-1:0] raw;
        logic signed [RAW_SUM_W-1:0] lim;
        for (int c = 0; c < NUM_CH; c++) begin
            mag = speed_reg[c][SPEED_W-1] ? -ERR_W'(speed_reg[c]) : ERR_W'(speed_reg[c]);
            err_next[c] = $signed({{(ERR_W-SETPOINT_W){1'b0}}, setpoint_reg}) - mag;
            raw = RAW_SUM_W'(sum_state_reg[c]) + RAW_SUM_W'(err_next[c]);
            lim = $signed({{(RAW_SUM_W-LIMIT_W){1'b0}}, limit_reg});
            if (raw > lim) begin
                int_next[c] = SUM_W'(lim);
            end else if (raw < -lim) begin
                int_next[c] = SUM_W'(-lim);
            end else begin
                int_next[c] = SUM_W'(raw);
            end
            diff_next[c] = err_next[c] - last_err_reg[c];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < NUM_CH; c++) begin
                sum_state_reg[c] <= '0;
                last_err_reg[c]  <= LAST_ERR_RST;
            end
        end else if (v1_reg && free2) begin
            for (int c = 0; c < NUM_CH; c++) begin
                sum_state_reg[c] <= int_next[c];
                last_err_reg[c]  <= err_next[c];
            end
        end
    end

    // Final stage logic: add the terms and bias, clamp, drop the fraction.
    always_comb begin
        logic signed [ACC_W-1:0] acc;
        logic signed [ACC_W-1:0] bias_q;
        logic        [ACC_W-FRAC_W-1:0] whole;
        bias_q = $signed({{(ACC_W-BIAS_W-FRAC_W){1'b0}}, bias_reg, {FRAC_W{1'b0}}});
        for (int c = 0; c < NUM_CH; c++) begin
            acc = ACC_W'(p_prod_reg[c]) + ACC_W'(i_prod_reg[c])
                + ACC_W'(d_prod_reg[c]) + bias_q;
            whole = acc[ACC_W-1:FRAC_W];
            if (acc[ACC_W-1]) begin
                cmp_next[c] = '0;
            end else if (whole > (ACC_W-FRAC_W)'(out_max_reg)) begin
                cmp_next[c] = out_max_reg;
            end else begin
                cmp_next[c] = whole[OUT_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (free1 && s_valid) begin
            speed_reg[0] <= s_left_speed;
            speed_reg[1] <= s_right_speed;
        end
        if (free2 && v1_reg) begin
            err_reg  <= err_next;
            int_reg  <= int_next;
            diff_reg <= diff_next;
        end
        if (free3 && v2_reg) begin
            for (int c = 0; c < NUM_CH; c++) begin
                p_prod_reg[c] <= PROD_W'($signed({1'b0, prop_gain_reg}))
                               * PROD_W'(err_reg[c]);
                i_prod_reg[c] <= PROD_W'($signed({1'b0, integ_gain_reg}))
                               * PROD_W'(int_reg[c]);
                d_prod_reg[c] <= PROD_W'($signed({1'b0, deriv_gain_reg}))
                               * PROD_W'(diff_reg[c]);
            end
        end
        if (free_out && v3_reg) begin
            cmp_reg <= cmp_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_left_compare  = cmp_reg[0];
    assign m_right_compare = cmp_reg[1];

`ifndef ASSERT_OFF
    // A full pipeline with a stalled output must refuse new requests.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (v1_reg && v2_reg && v3_reg && m_valid_reg && !m_ready) |-> !s_ready)
        else $error("request accepted into a full pipeline");

    // Controller state changes only when an item leaves the input stage.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(v1_reg && free2) |=> ($stable(last_err_reg[0]) && $stable(last_err_reg[1])
                               && $stable(sum_state_reg[0]) && $stable(sum_state_reg[1])))
        else $error("controller state changed without an item");

    // Delivered compare values never exceed the configured maximum.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_left_compare <= out_max_reg && m_right_compare <= out_max_reg))
        else $error("compare value above output maximum");

    // A result can only appear if the product stage held an item.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(v3_reg))
        else $error("result without a preceding item");
`endif

endmodule
